>>> design/vra_pkg.sv
package vra_pkg;

	localparam int MAX_ITEMS = 64;
	localparam int IDX_W     = $clog2(MAX_ITEMS);
	localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
	localparam int VAL_W     = 32;
	localparam int RANK_W    = 6;

	typedef enum logic [4:0] {
		ST_COLLECT = 5'b00001,
		ST_LOAD_I  = 5'b00010,
		ST_SCAN    = 5'b00100,
		ST_FLUSH   = 5'b01000,
		ST_RESULT  = 5'b10000
	} vra_state_t;

	typedef struct packed {
		logic store_en;   // write request value into the store
		logic ovf_set;    // request dropped, store full
		logic ld_i;       // read element i, clear rank and scan index
		logic scan;       // read element j, advance j
		logic out_load;   // move rank into the output register
		logic next_i;     // advance to the next element
		logic seq_clr;    // clear count, overflow flag and element index
	} vra_cmd_t;

	typedef struct packed {
		logic cnt_full;
		logic j_last;
		logic i_last;
		logic out_free;
	} vra_status_t;

endpackage

>>> design/value_rank_assigner_core.sv
// Ranks a sequence of signed 32-bit values. Requests are taken one per cycle
// while req_stall is low and stored, up to 64 of them; further requests are
// dropped and flag the results as truncated. The request marked last_item
// starts ranking: one result per stored value, in arrival order, giving its
// ascending sorted position, ties broken by arrival order. req_stall stays
// high from the last request until the final result has been loaded into the
// output register. Each result is built by loading element i, then by a scan
// that reads the store one element per cycle through its compare read port,
// and a flush of the compare stage; the rank waits for a free output register.
module value_rank_assigner_core import vra_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    req_valid,
	output logic                    req_stall,
	input  logic signed [VAL_W-1:0] value,
	input  logic                    last_item,
	output logic                    res_valid,
	input  logic                    res_stall,
	output logic [RANK_W-1:0]       rank,
	output logic                    final_result,
	output logic                    truncated
);

	vra_cmd_t    cmd;
	vra_status_t st;

	vra_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.last_item (last_item),
		.req_stall (req_stall),
		.st        (st),
		.cmd       (cmd)
	);

	vra_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.value        (value),
		.cmd          (cmd),
		.st           (st),
		.res_stall    (res_stall),
		.res_valid    (res_valid),
		.rank         (rank),
		.final_result (final_result),
		.truncated    (truncated)
	);

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> st.out_free)
		else $error("result loaded over a pending one");

	a_store_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.store_en |-> !st.cnt_full)
		else $error("store written past capacity");

	a_load_then_scan: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ld_i |=> cmd.scan)
		else $error("element load not followed by scan");

endmodule

>>> design/vra_ctrl.sv
module vra_ctrl import vra_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	input  logic        last_item,
	output logic        req_stall,
	input  vra_status_t st,
	output vra_cmd_t    cmd
);

	vra_state_t state_q, state_d;
	logic       req_acc;

	assign req_stall = (state_q != ST_COLLECT);
	assign req_acc   = req_valid && !req_stall;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_COLLECT: begin
				if (req_acc) begin
					cmd.store_en = !st.cnt_full;
					cmd.ovf_set  = st.cnt_full;
					if (last_item)
						state_d = ST_LOAD_I;
				end
			end
			ST_LOAD_I: begin
				cmd.ld_i = 1'b1;
				state_d  = ST_SCAN;
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (st.j_last)
					state_d = ST_FLUSH;
			end
			ST_FLUSH: begin
				state_d = ST_RESULT;
			end
			ST_RESULT: begin
				if (st.out_free) begin
					cmd.out_load = 1'b1;
					if (st.i_last) begin
						cmd.seq_clr = 1'b1;
						state_d     = ST_COLLECT;
					end else begin
						cmd.next_i = 1'b1;
						state_d    = ST_LOAD_I;
					end
				end
			end
			default: begin
				state_d = ST_COLLECT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_COLLECT;
		else
			state_q <= state_d;
	end

endmodule

>>> design/vra_dp.sv
module vra_dp import vra_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic signed [VAL_W-1:0] value,
	input  vra_cmd_t                cmd,
	output vra_status_t             st,
	input  logic                    res_stall,
	output logic                    res_valid,
	output logic [RANK_W-1:0]       rank,
	output logic                    final_result,
	output logic                    truncated
);

	logic signed [VAL_W-1:0] mem [MAX_ITEMS];
	logic signed [VAL_W-1:0] val_i_q;
	logic signed [VAL_W-1:0] val_j_s1;
	logic [CNT_W-1:0]        cnt_q;
	logic                    ovf_q;
	logic [IDX_W-1:0]        i_q;
	logic [IDX_W-1:0]        j_q;
	logic [IDX_W-1:0]        j_s1;
	logic                    vld_s1;
	logic [RANK_W-1:0]       rank_q;
	logic                    out_vld_q;
	logic [RANK_W-1:0]       out_rank_q;
	logic                    out_fin_q;
	logic                    out_trc_q;
	logic [CNT_W-1:0]        last_idx;
	logic                    below;

	assign last_idx    = cnt_q - CNT_W'(1);
	assign st.cnt_full = (cnt_q == CNT_W'(MAX_ITEMS));
	assign st.j_last   = ({1'b0, j_q} == last_idx);
	assign st.i_last   = ({1'b0, i_q} == last_idx);
	assign st.out_free = !out_vld_q || !res_stall;

	assign below = (val_j_s1 < val_i_q) || ((val_j_s1 == val_i_q) && (j_s1 < i_q));

	always_ff @(posedge clk) begin
		if (cmd.store_en)
			mem[cnt_q[IDX_W-1:0]] <= value;
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_i)
			val_i_q <= mem[i_q];
		if (cmd.scan) begin
			val_j_s1 <= mem[j_q];
			j_s1     <= j_q;
		end
		if (cmd.out_load) begin
			out_rank_q <= rank_q;
			out_fin_q  <= st.i_last;
			out_trc_q  <= ovf_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			ovf_q     <= 1'b0;
			i_q       <= '0;
			j_q       <= '0;
			vld_s1    <= 1'b0;
			rank_q    <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (cmd.store_en)
				cnt_q <= cnt_q + CNT_W'(1);
			if (cmd.ovf_set)
				ovf_q <= 1'b1;
			if (cmd.seq_clr) begin
				cnt_q <= '0;
				ovf_q <= 1'b0;
				i_q   <= '0;
			end else if (cmd.next_i) begin
				i_q <= i_q + IDX_W'(1);
			end
			vld_s1 <= cmd.scan;
			if (cmd.ld_i) begin
				j_q    <= '0;
				rank_q <= '0;
			end else begin
				if (cmd.scan)
					j_q <= j_q + IDX_W'(1);
				if (vld_s1 && below)
					rank_q <= rank_q + RANK_W'(1);
			end
			if (cmd.out_load)
				out_vld_q <= 1'b1;
			else if (!res_stall)
				out_vld_q <= 1'b0;
		end
	end

	assign res_valid    = out_vld_q;
	assign rank         = out_rank_q;
	assign final_result = out_fin_q;
	assign truncated    = out_trc_q;

endmodule
